// ===== design/pex_pkg.sv =====
package pex_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int OPERAND_WIDTH = 32;
  localparam int ANSWER_W      = 32;
  localparam int PTR_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef logic [OPERAND_WIDTH-1:0] value_t;
  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [ANSWER_W-1:0] answer_t;

  localparam value_t TEN = value_t'(10);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_OPER  = 2'd1,
    CLS_CLOSE = 2'd2,
    CLS_OTHER = 2'd3
  } sym_class_t;

  typedef struct packed {
    value_t  value;
    logic    is_op;
    opcode_t opcode;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic [1:0] rd_off;
    logic       lat_right;
    logic       lat_op;
    logic       lat_left;
    logic       pop3;
    logic       push_digit;
    logic       push_op;
    logic       push_res;
    logic       extend;
    logic       clr_prev;
    logic       flag_en;
    status_t    flag_code;
    logic       res_arith;
    logic       res_zero;
    logic       div_start;
    logic       res_div;
    logic       ans_zero;
    logic       ans_lat;
    logic       emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    sym_class_t cls;
    logic       end_mark;
    logic       prev_digit;
    logic       sp_zero;
    logic       sp_lt3;
    logic       top_is_op;
    logic       op_is_div;
    logic       right_zero;
    logic       div_done;
    logic       out_busy;
  } stat_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t cls;
    if (sym >= CH_ZERO && sym <= CH_NINE) cls = CLS_DIGIT;
    else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH)
      cls = CLS_OPER;
    else if (sym == CH_CLOSE) cls = CLS_CLOSE;
    else cls = CLS_OTHER;
    return cls;
  endfunction

  function automatic opcode_t opcode_of(input logic [7:0] sym);
    opcode_t op;
    if (sym == CH_PLUS) op = OP_ADD;
    else if (sym == CH_MINUS) op = OP_SUB;
    else if (sym == CH_STAR) op = OP_MUL;
    else op = OP_DIV;
    return op;
  endfunction

endpackage

// ===== design/pex_div.sv =====
module pex_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pex_pkg::value_t  dividend,
  input  pex_pkg::value_t  divisor,
  output logic             busy,
  output logic             done,
  output pex_pkg::value_t  quotient
);

  localparam int W     = pex_pkg::OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, quo_r, mb_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  logic [W-1:0] ma, mb;
  logic [W:0]   rem_sh;
  logic         ge;

  assign ma     = dividend[W-1] ? (~dividend + 1'b1) : dividend;
  assign mb     = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign ge     = rem_sh >= {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= ma;
      mb_r  <= mb;
      neg_r <= dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= W'(rem_sh - {1'b0, mb_r});
      end else begin
        rem_r <= rem_sh[W-1:0];
      end
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == CNT_W'(W))
    else $error("divider did not start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a run");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");

endmodule

// ===== design/pex_dpath.sv =====
module pex_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_symbol,
  input  logic                  in_end_of_expression,
  input  pex_pkg::cmd_t         cmd,
  output pex_pkg::stat_t        stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pex_pkg::answer_t      out_answer,
  output logic [1:0]            out_status
);

  localparam int DEPTH = pex_pkg::STACK_DEPTH;

  pex_pkg::entry_t  mem [DEPTH];
  pex_pkg::entry_t  rd_data_r;

  logic [7:0]       sym_r;
  logic             end_r;
  pex_pkg::ptr_t    sp_r, sp_nxt;
  logic             prev_r, prev_nxt;
  pex_pkg::status_t err_r, err_nxt;
  pex_pkg::value_t  right_r, left_r, res_r, ans_r;
  pex_pkg::opcode_t op_r;

  logic             out_valid_r;
  pex_pkg::answer_t out_answer_r;
  pex_pkg::status_t out_status_r;

  logic             full, push_any, wr_en;
  logic [3:0]       digit;
  pex_pkg::ptr_t    rd_ptr, wr_ptr;
  pex_pkg::entry_t  wr_data;
  pex_pkg::value_t  top_operand;
  pex_pkg::value_t  div_q;
  logic             div_busy, div_done;

  assign full        = sp_r == pex_pkg::ptr_t'(DEPTH);
  assign push_any    = cmd.push_digit | cmd.push_op | cmd.push_res;
  assign wr_en       = (push_any && !full) || cmd.extend;
  assign digit       = 4'(sym_r - pex_pkg::CH_ZERO);
  assign rd_ptr      = sp_r - pex_pkg::ptr_t'(cmd.rd_off);
  assign wr_ptr      = cmd.extend ? (sp_r - pex_pkg::ptr_t'(1)) : sp_r;
  assign top_operand = rd_data_r.is_op ? '0 : rd_data_r.value;

  always_comb begin
    wr_data        = '0;
    wr_data.opcode = pex_pkg::OP_ADD;
    if (cmd.extend) begin
      wr_data.value = rd_data_r.value * pex_pkg::TEN + pex_pkg::value_t'(digit);
    end else if (cmd.push_digit) begin
      wr_data.value = pex_pkg::value_t'(digit);
    end else if (cmd.push_op) begin
      wr_data.is_op  = 1'b1;
      wr_data.opcode = pex_pkg::opcode_of(sym_r);
    end else begin
      wr_data.value = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr[pex_pkg::ADDR_W-1:0]] <= wr_data;
    if (cmd.rd_en) rd_data_r <= mem[rd_ptr[pex_pkg::ADDR_W-1:0]];
  end

  always_comb begin
    sp_nxt   = sp_r;
    prev_nxt = prev_r;
    err_nxt  = err_r;
    if (cmd.pop3) sp_nxt = sp_r - pex_pkg::ptr_t'(3);
    else if (push_any && !full) sp_nxt = sp_r + pex_pkg::ptr_t'(1);
    if (cmd.clr_prev || cmd.push_op) prev_nxt = 1'b0;
    else if (cmd.push_digit) prev_nxt = !full;
    else if (cmd.extend) prev_nxt = 1'b1;
    // first error sticks
    if (err_r == pex_pkg::ST_OK) begin
      if (push_any && full) err_nxt = pex_pkg::ST_OVER;
      else if (cmd.flag_en) err_nxt = cmd.flag_code;
    end
    if (cmd.emit) begin
      sp_nxt   = '0;
      prev_nxt = 1'b0;
      err_nxt  = pex_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      prev_r <= 1'b0;
      err_r  <= pex_pkg::ST_OK;
    end else begin
      sp_r   <= sp_nxt;
      prev_r <= prev_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sym_r <= in_symbol;
      end_r <= in_end_of_expression;
    end
    if (cmd.lat_right) right_r <= top_operand;
    if (cmd.lat_op) op_r <= rd_data_r.is_op ? rd_data_r.opcode : pex_pkg::OP_ADD;
    if (cmd.lat_left) left_r <= top_operand;
    if (cmd.res_arith) begin
      case (op_r)
        pex_pkg::OP_SUB: res_r <= left_r - right_r;
        pex_pkg::OP_MUL: res_r <= left_r * right_r;
        default:         res_r <= left_r + right_r;
      endcase
    end else if (cmd.res_zero) begin
      res_r <= '0;
    end else if (cmd.res_div) begin
      res_r <= div_q;
    end
    if (cmd.ans_zero) ans_r <= '0;
    else if (cmd.ans_lat) ans_r <= top_operand;
  end

  pex_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (left_r),
    .divisor  (right_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_answer_r <= pex_pkg::answer_t'($signed(ans_r));
      out_status_r <= err_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

  always_comb begin
    stat            = '0;
    stat.cls        = pex_pkg::classify(sym_r);
    stat.end_mark   = end_r;
    stat.prev_digit = prev_r;
    stat.sp_zero    = sp_r == '0;
    stat.sp_lt3     = sp_r < pex_pkg::ptr_t'(3);
    stat.top_is_op  = rd_data_r.is_op;
    stat.op_is_div  = op_r == pex_pkg::OP_DIV;
    stat.right_zero = right_r == '0;
    stat.div_done   = div_done && !div_busy;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> sp_r == '0 && err_r == pex_pkg::ST_OK && !prev_r)
    else $error("state not cleared after end of expression");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != pex_pkg::ST_OK && !cmd.emit |=> err_r == $past(err_r))
    else $error("error status changed");

  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop3 |-> sp_r >= pex_pkg::ptr_t'(3))
    else $error("pop below stack bottom");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    push_any && full |=> sp_r == pex_pkg::ptr_t'(DEPTH))
    else $error("push onto full stack moved pointer");

endmodule

// ===== design/pex_ctrl.sv =====
module pex_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pex_pkg::stat_t stat,
  output pex_pkg::cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_DIGIT  = 12'b000000000100,
    S_RD_R   = 12'b000000001000,
    S_RD_OP  = 12'b000000010000,
    S_RD_L   = 12'b000000100000,
    S_EXEC   = 12'b000001000000,
    S_DIV    = 12'b000010000000,
    S_PUSH   = 12'b000100000000,
    S_FINISH = 12'b001000000000,
    S_RD_ANS = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.cls)
          pex_pkg::CLS_DIGIT: begin
            if (stat.prev_digit && !stat.sp_zero) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_off = 2'd1;
              state_nxt  = S_DIGIT;
            end else begin
              cmd.push_digit = 1'b1;
            end
          end
          pex_pkg::CLS_OPER: cmd.push_op = 1'b1;
          pex_pkg::CLS_CLOSE: begin
            cmd.clr_prev = 1'b1;
            if (stat.sp_lt3) begin
              cmd.flag_en   = 1'b1;
              cmd.flag_code = pex_pkg::ST_UNDER;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_off = 2'd1;
              state_nxt  = S_RD_R;
            end
          end
          default: ;
        endcase
      end
      S_DIGIT: begin
        // keep building the number only when the top is an operand
        if (stat.top_is_op) cmd.push_digit = 1'b1;
        else cmd.extend = 1'b1;
        state_nxt = S_FINISH;
      end
      S_RD_R: begin
        cmd.lat_right = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_off    = 2'd2;
        state_nxt     = S_RD_OP;
      end
      S_RD_OP: begin
        cmd.lat_op = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 2'd3;
        state_nxt  = S_RD_L;
      end
      S_RD_L: begin
        cmd.lat_left = 1'b1;
        cmd.pop3     = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.op_is_div) begin
          cmd.res_arith = 1'b1;
          state_nxt     = S_PUSH;
        end else if (stat.right_zero) begin
          cmd.res_zero  = 1'b1;
          cmd.flag_en   = 1'b1;
          cmd.flag_code = pex_pkg::ST_DIV0;
          state_nxt     = S_PUSH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.res_div = 1'b1;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.end_mark) begin
          state_nxt = S_IDLE;
        end else if (stat.sp_zero) begin
          cmd.ans_zero  = 1'b1;
          cmd.flag_en   = 1'b1;
          cmd.flag_code = pex_pkg::ST_UNDER;
          state_nxt     = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = 2'd1;
          state_nxt  = S_RD_ANS;
        end
      end
      S_RD_ANS: begin
        cmd.ans_lat = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIV)
    else $error("divide started without waiting");

  a_emit_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && stat.out_busy |=> state_r == S_EMIT)
    else $error("result word dropped");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

endmodule

// ===== design/parenthesized_expression_evaluator_unit.sv =====
// processing: each accepted digit, operator or ignored character is decoded and pushed or dropped;
// ')' reads the right operand, operator and left operand, then computes and pushes the result, and
// ')' with / waits on the iterative divider (one quotient bit a cycle); the end mark reads the answer
// and the output word comes last; throughput: one word at a time, the next one accepted only once
// the last is done, later while a finished output word still waits for out_ready
// reset: synchronous active-low rst_n empties the stack and clears the error status
module parenthesized_expression_evaluator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_symbol,
  input  logic                in_end_of_expression,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_answer,
  output logic [1:0]          out_status
);

  pex_pkg::cmd_t  cmd;
  pex_pkg::stat_t stat;

  pex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pex_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_symbol            (in_symbol),
    .in_end_of_expression (in_end_of_expression),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_answer           (out_answer),
    .out_status           (out_status)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int         WORD_GOAL = 1900;

  // predicts the answer word of each expression and checks what comes out
  class answer_tracker;
    typedef struct {
      pex_pkg::answer_t answer;
      pex_pkg::status_t status;
    } answer_rec_t;

    answer_rec_t      pending_answers[$];
    pex_pkg::value_t  stk_val[pex_pkg::STACK_DEPTH];
    bit               stk_op[pex_pkg::STACK_DEPTH];
    pex_pkg::opcode_t stk_code[pex_pkg::STACK_DEPTH];
    int unsigned      sp;
    bit               in_number;
    pex_pkg::status_t err;
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      clear_stack();
    endfunction

    function void clear_stack();
      sp = 0;
      in_number = 1'b0;
      err = pex_pkg::ST_OK;
    endfunction

    // first error sticks until the expression ends
    function void note_error(pex_pkg::status_t code);
      if (err == pex_pkg::ST_OK) err = code;
    endfunction

    function bit push_entry(pex_pkg::value_t v, bit is_op, pex_pkg::opcode_t code);
      if (sp >= pex_pkg::STACK_DEPTH) begin
        note_error(pex_pkg::ST_OVER);
        return 1'b0;
      end
      stk_val[sp] = v;
      stk_op[sp] = is_op;
      stk_code[sp] = code;
      sp++;
      return 1'b1;
    endfunction

    function pex_pkg::value_t operand_at(int unsigned idx);
      return stk_op[idx] ? '0 : stk_val[idx];
    endfunction

    // signed divide on magnitudes, truncating toward zero; min / -1 wraps
    function pex_pkg::value_t quotient(pex_pkg::value_t num, pex_pkg::value_t den);
      pex_pkg::value_t ma, mb, q;
      bit              na, nb;
      na = num[pex_pkg::OPERAND_WIDTH-1];
      nb = den[pex_pkg::OPERAND_WIDTH-1];
      ma = na ? pex_pkg::value_t'(0) - num : num;
      mb = nb ? pex_pkg::value_t'(0) - den : den;
      q = ma / mb;
      return (na != nb) ? pex_pkg::value_t'(0) - q : q;
    endfunction

    function void close_group();
      pex_pkg::value_t  right, left, result;
      pex_pkg::opcode_t code;
      int unsigned      top;
      in_number = 1'b0;
      if (sp < 3) begin
        note_error(pex_pkg::ST_UNDER);
        return;
      end
      top = sp - 1;
      right = operand_at(top);
      code = stk_op[top-1] ? stk_code[top-1] : pex_pkg::OP_ADD;
      left = operand_at(top - 2);
      sp -= 3;
      case (code)
        pex_pkg::OP_ADD: result = left + right;
        pex_pkg::OP_SUB: result = left - right;
        pex_pkg::OP_MUL: result = left * right;
        default: begin
          if (right == '0) begin
            note_error(pex_pkg::ST_DIV0);
            result = '0;
          end else begin
            result = quotient(left, right);
          end
        end
      endcase
      void'(push_entry(result, 1'b0, pex_pkg::OP_ADD));
    endfunction

    function void take_symbol(logic [7:0] sym, logic last);
      answer_rec_t      rec;
      pex_pkg::opcode_t code;
      pex_pkg::value_t  digit;
      digit = pex_pkg::value_t'(sym - pex_pkg::CH_ZERO);
      if (sym >= pex_pkg::CH_ZERO && sym <= pex_pkg::CH_NINE) begin
        if (in_number && sp > 0 && !stk_op[sp-1])
          stk_val[sp-1] = stk_val[sp-1] * pex_pkg::TEN + digit;
        else
          in_number = push_entry(digit, 1'b0, pex_pkg::OP_ADD);
      end else if (sym == pex_pkg::CH_PLUS || sym == pex_pkg::CH_MINUS ||
                   sym == pex_pkg::CH_STAR || sym == pex_pkg::CH_SLASH) begin
        case (sym)
          pex_pkg::CH_PLUS:  code = pex_pkg::OP_ADD;
          pex_pkg::CH_MINUS: code = pex_pkg::OP_SUB;
          pex_pkg::CH_STAR:  code = pex_pkg::OP_MUL;
          default:           code = pex_pkg::OP_DIV;
        endcase
        void'(push_entry('0, 1'b1, code));
        in_number = 1'b0;
      end else if (sym == pex_pkg::CH_CLOSE) begin
        close_group();
      end
      if (last) begin
        if (sp == 0) begin
          note_error(pex_pkg::ST_UNDER);
          rec.answer = '0;
        end else begin
          rec.answer = pex_pkg::answer_t'(operand_at(sp - 1));
        end
        rec.status = err;
        pending_answers.push_back(rec);
        clear_stack();
      end
    endfunction

    function void check_answer(pex_pkg::answer_t got_answer, logic [1:0] got_status);
      answer_rec_t rec;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected answer word %0d status %0d", got_answer, got_status);
        return;
      end
      rec = pending_answers.pop_front();
      if (got_answer !== rec.answer || got_status !== rec.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch answer exp %0d got %0d, status exp %0d got %0d",
                   rec.answer, got_answer, rec.status, got_status);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_symbol = 8'h00;
  logic              in_end_of_expression = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [31:0] out_answer;
  logic [1:0]        out_status;

  answer_tracker tracker = new();
  logic [7:0]    expr_text[$];
  bit            gaps_on = 1'b1;
  int unsigned   active_words = 0;

  parenthesized_expression_evaluator_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_symbol            (in_symbol),
    .in_end_of_expression (in_end_of_expression),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_answer           (out_answer),
    .out_status           (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_answer(out_answer, out_status);
  end

  function automatic void add_chars(string s);
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] ops[4];
    ops = '{pex_pkg::CH_PLUS, pex_pkg::CH_MINUS, pex_pkg::CH_STAR, pex_pkg::CH_SLASH};
    return ops[$urandom_range(3)];
  endfunction

  function automatic void add_number();
    int unsigned pick, n;
    pick = $urandom_range(99);
    if (pick < 50) begin
      add_chars($sformatf("%0d", $urandom_range(99)));
    end else if (pick < 65) begin
      add_chars($sformatf("%0d", $urandom));
    end else if (pick < 75) begin
      add_chars("0");
    end else if (pick < 83) begin
      add_chars("2147483648");
    end else if (pick < 90) begin
      add_chars("4294967295");
    end else begin
      // long runs wrap while the number is built
      n = $urandom_range(1, 14);
      repeat (n) expr_text.push_back(pex_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    // a space inside or after a number changes nothing
    if ($urandom_range(19) == 0) expr_text.push_back(CH_SPACE);
  endfunction

  function automatic void add_group(int levels);
    if ($urandom_range(9) != 0) expr_text.push_back(CH_OPEN);
    add_operand(levels - 1);
    expr_text.push_back(pick_op());
    add_operand(levels - 1);
    expr_text.push_back(pex_pkg::CH_CLOSE);
  endfunction

  function automatic void add_operand(int levels);
    if (levels <= 0 || $urandom_range(2) == 0) add_number();
    else add_group(levels);
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_end_of_expression <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_symbol(sym, last);
    active_words++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_text.size(); i++) send_word(expr_text[i], i == expr_text.size() - 1);
    expr_text.delete();
  endtask

  initial begin
    int unsigned kind, n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end mark on an empty stack
    expr_text.push_back(8'h00);
    send_expr();
    // divide by zero inside a group
    add_chars("(6/0)");
    send_expr();
    // too few entries at close, then an ignored end word
    add_chars("1)");
    expr_text.push_back(8'hFF);
    send_expr();
    // close ends a number; later digits start a fresh one
    add_chars("2*3)45)");
    send_expr();
    // operator entries read as zero operands; leftovers dropped at end
    add_chars("9--)7-3)");
    send_expr();

    while (active_words < WORD_GOAL) begin
      gaps_on = !(active_words >= 700 && active_words < 1000);
      kind = $urandom_range(99);
      if (kind < 68) begin
        if ($urandom_range(6) == 0) add_number();
        add_group(($urandom_range(9) == 0) ? 6 : $urandom_range(1, 3));
      end else if (kind < 76) begin
        expr_text.push_back(CH_OPEN);
        case ($urandom_range(2))
          0: add_chars("2147483648");
          1: add_chars("4294967295");
          default: add_number();
        endcase
        expr_text.push_back(pex_pkg::CH_SLASH);
        case ($urandom_range(2))
          0: add_chars("4294967295");
          1: add_chars("0");
          default: add_chars("2147483648");
        endcase
        expr_text.push_back(pex_pkg::CH_CLOSE);
      end else if (kind < 84) begin
        // push runs of digits and operators that can flood the stack past its depth
        n = $urandom_range(14, 24);
        repeat (n) begin
          if ($urandom_range(1) == 0) expr_text.push_back(pick_op());
          else expr_text.push_back(pex_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(1) == 0) expr_text.push_back(pex_pkg::CH_CLOSE);
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          case ($urandom_range(4))
            0, 1: expr_text.push_back(8'($urandom_range(255)));
            2: expr_text.push_back(pex_pkg::CH_ZERO + 8'($urandom_range(9)));
            3: expr_text.push_back(pick_op());
            default: expr_text.push_back($urandom_range(1) ? pex_pkg::CH_CLOSE : CH_OPEN);
          endcase
        end
      end
      send_expr();
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
